// ===== hdl/hss_pkg.sv =====
`timescale 1ns / 1ps

package hss_pkg;

    // Field widths
    localparam int NOW_W      = 32;
    localparam int STATUS_W   = 8;
    localparam int RAW_W      = 20;
    localparam int WAIT_W     = 16;
    localparam int OFFSET_W   = 11;
    localparam int CMD_W      = 2;
    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int CODE_W     = 3;
    localparam int REASON_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    // Bus commands
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT_TRG = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRIGGER  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

    // Disable reasons
    localparam logic [REASON_W-1:0] RSN_NONE       = 3'd0;
    localparam logic [REASON_W-1:0] RSN_ABSENT     = 3'd1;
    localparam logic [REASON_W-1:0] RSN_UNCAL      = 3'd2;
    localparam logic [REASON_W-1:0] RSN_CAL_TMO    = 3'd3;
    localparam logic [REASON_W-1:0] RSN_TRIG_FAIL  = 3'd4;
    localparam logic [REASON_W-1:0] RSN_READ_FAIL  = 3'd5;

    // Externally visible state codes
    localparam logic [CODE_W-1:0] CODE_UNINIT   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_POWERON  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_CAL      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_FIRST    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd4;
    localparam logic [CODE_W-1:0] CODE_MEAS     = 3'd5;
    localparam logic [CODE_W-1:0] CODE_DISABLED = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_WAIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_WAIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_PERIOD = 3'd6;

    // Configuration reset values
    localparam logic signed [OFFSET_W-1:0] RST_TEMP_OFFSET = -11'sd300;
    localparam logic [WAIT_W-1:0] RST_POWER_ON    = 16'd40;
    localparam logic [WAIT_W-1:0] RST_CAL_WAIT    = 16'd75;
    localparam logic [WAIT_W-1:0] RST_CAL_TIMEOUT = 16'd175;
    localparam logic [WAIT_W-1:0] RST_FIRST_WAIT  = 16'd100;
    localparam logic [WAIT_W-1:0] RST_MEAS_WAIT   = 16'd75;
    localparam logic [WAIT_W-1:0] RST_MEAS_PERIOD = 16'd1000;

    // Status bits
    localparam int BUSY_BIT = 7;
    localparam int CAL_BIT  = 3;

    // Conversion: value = raw * scale / 2^20; temperature then subtracts TEMP_BIAS and adds the offset
    localparam int                 FRAC_W     = 20;
    localparam logic [14:0]        TEMP_SCALE = 15'd20000;
    localparam logic [13:0]        HUM_SCALE  = 14'd10000;
    localparam logic signed [15:0] TEMP_BIAS  = 16'sd5000;

    typedef enum logic [6:0] {
        ST_UNINIT   = 7'b0000001,
        ST_POWERON  = 7'b0000010,
        ST_CAL      = 7'b0000100,
        ST_FIRST    = 7'b0001000,
        ST_IDLE     = 7'b0010000,
        ST_MEAS     = 7'b0100000,
        ST_DISABLED = 7'b1000000
    } seq_state_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] temp_offset_centi;
        logic [WAIT_W-1:0]          power_on_wait_ms;
        logic [WAIT_W-1:0]          cal_wait_ms;
        logic [WAIT_W-1:0]          cal_timeout_ms;
        logic [WAIT_W-1:0]          first_meas_wait_ms;
        logic [WAIT_W-1:0]          meas_wait_ms;
        logic [WAIT_W-1:0]          meas_period_ms;
    } hss_cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0]    now_ms;
        logic                device_present;
        logic [STATUS_W-1:0] status_byte;
        logic                command_ack;
        logic                read_ok;
        logic [RAW_W-1:0]    raw_humidity;
        logic [RAW_W-1:0]    raw_temperature;
    } hss_in_t;

    typedef struct packed {
        logic [CMD_W-1:0]         bus_command;
        logic                     report_valid;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic [HUM_W-1:0]         humidity_centi;
        logic [CODE_W-1:0]        sequence_state;
        logic [REASON_W-1:0]      disable_reason;
    } hss_res_t;

    function automatic logic [CODE_W-1:0] state_code(input seq_state_t st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_UNINIT:  code = CODE_UNINIT;
            ST_POWERON: code = CODE_POWERON;
            ST_CAL:     code = CODE_CAL;
            ST_FIRST:   code = CODE_FIRST;
            ST_IDLE:    code = CODE_IDLE;
            ST_MEAS:    code = CODE_MEAS;
            default:    code = CODE_DISABLED;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/hss_cfg.sv =====
`timescale 1ns / 1ps

module hss_cfg
    import hss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output hss_cfg_t              cfg
);

    hss_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_offset_centi  <= RST_TEMP_OFFSET;
            cfg_reg.power_on_wait_ms   <= RST_POWER_ON;
            cfg_reg.cal_wait_ms        <= RST_CAL_WAIT;
            cfg_reg.cal_timeout_ms     <= RST_CAL_TIMEOUT;
            cfg_reg.first_meas_wait_ms <= RST_FIRST_WAIT;
            cfg_reg.meas_wait_ms       <= RST_MEAS_WAIT;
            cfg_reg.meas_period_ms     <= RST_MEAS_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_OFFSET: cfg_reg.temp_offset_centi  <= cfg_data[OFFSET_W-1:0];
                REG_POWER_ON:    cfg_reg.power_on_wait_ms   <= cfg_data;
                REG_CAL_WAIT:    cfg_reg.cal_wait_ms        <= cfg_data;
                REG_CAL_TIMEOUT: cfg_reg.cal_timeout_ms     <= cfg_data;
                REG_FIRST_WAIT:  cfg_reg.first_meas_wait_ms <= cfg_data;
                REG_MEAS_WAIT:   cfg_reg.meas_wait_ms       <= cfg_data;
                REG_MEAS_PERIOD: cfg_reg.meas_period_ms     <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/hss_core.sv =====
`timescale 1ns / 1ps

module hss_core
    import hss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  hss_in_t  item,
    input  hss_cfg_t cfg,
    output hss_res_t res
);

    seq_state_t          seq_reg, seq_next;
    logic [NOW_W-1:0]    last_reg, last_next;
    logic [WAIT_W-1:0]   pend_reg, pend_next;
    logic [REASON_W-1:0] reason_reg, reason_next;

    logic [NOW_W-1:0]           dt;
    logic                       busy;
    logic                       calibrated;
    logic [RAW_W+15-1:0]        temp_prod;
    logic [RAW_W+14-1:0]        hum_prod;
    logic signed [15:0]         temp_full;
    logic [CMD_W-1:0]           cmd;
    logic                       rep_valid;
    logic                       rep_data;

    assign dt         = item.now_ms - last_reg;
    assign busy       = item.status_byte[BUSY_BIT];
    assign calibrated = item.status_byte[CAL_BIT];

    assign temp_prod = (RAW_W+15)'(item.raw_temperature) * (RAW_W+15)'(TEMP_SCALE);
    assign hum_prod  = (RAW_W+14)'(item.raw_humidity) * (RAW_W+14)'(HUM_SCALE);
    assign temp_full = $signed({1'b0, temp_prod[RAW_W+15-1:FRAC_W]}) - TEMP_BIAS
                     + 16'(cfg.temp_offset_centi);

    always_comb
    begin
        seq_next    = seq_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        reason_next = reason_reg;
        cmd         = CMD_NONE;
        rep_valid   = 1'b0;
        rep_data    = 1'b0;
        case (seq_reg)
            ST_UNINIT:
            begin
                if (!item.device_present)
                begin
                    seq_next    = ST_DISABLED;
                    reason_next = RSN_ABSENT;
                    rep_valid   = 1'b1;
                end
                else
                begin
                    last_next = item.now_ms;
                    seq_next  = ST_POWERON;
                end
            end
            ST_POWERON:
            begin
                if (dt >= NOW_W'(cfg.power_on_wait_ms))
                begin
                    last_next = item.now_ms;
                    if (!calibrated)
                    begin
                        cmd      = CMD_INIT_TRG;
                        seq_next = item.command_ack ? ST_CAL : ST_POWERON;
                    end
                    else
                    begin
                        pend_next = cfg.first_meas_wait_ms;
                        cmd       = CMD_TRIGGER;
                        if (item.command_ack)
                        begin
                            seq_next = ST_FIRST;
                        end
                        else
                        begin
                            seq_next    = ST_DISABLED;
                            reason_next = RSN_TRIG_FAIL;
                            rep_valid   = 1'b1;
                        end
                    end
                end
            end
            ST_CAL:
            begin
                if (dt >= NOW_W'(cfg.cal_wait_ms))
                begin
                    if (!busy)
                    begin
                        if (!calibrated)
                        begin
                            seq_next    = ST_DISABLED;
                            reason_next = RSN_UNCAL;
                            rep_valid   = 1'b1;
                        end
                        else
                        begin
                            pend_next = cfg.first_meas_wait_ms;
                            cmd       = CMD_TRIGGER;
                            last_next = item.now_ms;
                            if (item.command_ack)
                            begin
                                seq_next = ST_FIRST;
                            end
                            else
                            begin
                                seq_next    = ST_DISABLED;
                                reason_next = RSN_TRIG_FAIL;
                                rep_valid   = 1'b1;
                            end
                        end
                    end
                    else if (dt > NOW_W'(cfg.cal_timeout_ms))
                    begin
                        seq_next    = ST_DISABLED;
                        reason_next = RSN_CAL_TMO;
                        rep_valid   = 1'b1;
                    end
                end
            end
            ST_FIRST, ST_MEAS:
            begin
                if (dt > NOW_W'(pend_reg) && !busy)
                begin
                    cmd = CMD_READ;
                    if (!item.read_ok)
                    begin
                        seq_next    = ST_DISABLED;
                        reason_next = RSN_READ_FAIL;
                        rep_valid   = 1'b1;
                    end
                    else
                    begin
                        seq_next  = ST_IDLE;
                        rep_valid = 1'b1;
                        rep_data  = 1'b1;
                    end
                end
            end
            ST_IDLE:
            begin
                if (dt > NOW_W'(cfg.meas_period_ms))
                begin
                    pend_next = cfg.meas_wait_ms;
                    cmd       = CMD_TRIGGER;
                    last_next = item.now_ms;
                    seq_next  = item.command_ack ? ST_MEAS : ST_IDLE;
                end
            end
            default:
            begin
                seq_next  = ST_DISABLED;
                rep_valid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= ST_UNINIT;
            last_reg   <= '0;
            pend_reg   <= '0;
            reason_reg <= RSN_NONE;
        end
        else if (step)
        begin
            seq_reg    <= seq_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            reason_reg <= reason_next;
        end
    end

    always_comb
    begin
        res.bus_command       = cmd;
        res.report_valid      = rep_valid;
        res.temperature_centi = rep_data ? temp_full[TEMP_W-1:0] : '0;
        res.humidity_centi    = rep_data ? hum_prod[RAW_W+14-1:FRAC_W] : '0;
        res.sequence_state    = state_code(seq_next);
        res.disable_reason    = reason_next;
    end

    // The disabled state is terminal until reset.
    a_disabled_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == ST_DISABLED |=> seq_reg == ST_DISABLED)
        else $error("sequencer left the disabled state");

    // A reason is recorded exactly when the sequence is disabled.
    a_reason_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (reason_reg != RSN_NONE) == (seq_reg == ST_DISABLED))
        else $error("disable reason out of step with the state");

    // A real measurement report only comes with a read command and idle as next state.
    a_report_read: assert property (@(posedge clk) disable iff (!rst_n)
        step && rep_data |-> cmd == CMD_READ && seq_next == ST_IDLE)
        else $error("measurement report without a data read");

    // Time stamp moves only on a tick that issues a command or leaves uninit.
    a_stamp_moves: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_next != last_reg |-> cmd != CMD_NONE || seq_reg == ST_UNINIT)
        else $error("action time changed without an action");

endmodule

// ===== hdl/humidity_sensor_sequencer.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_*       in   88     one update tick: time, presence, status, ack, read result, raw data
// m_*       out  40     one result per tick: command, report, state, reason
// cfg_*     in   16     register writes, index 0..6, no read-back
//
// Each tick is computed combinationally between the input register and the result
// register; one tick is accepted per clock while m_tready does not stall the result.
// The sequence state and time stamps update as the tick leaves the input register.
// A stalled m_tready holds the result; the input register still takes one more item.
// rst_n clears the sequence to uninit and loads the register defaults.

module humidity_sensor_sequencer
    import hss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], device_present[32], status_byte[40:33], command_ack[41],
    // read_ok[42], raw_humidity[62:43], raw_temperature[82:63], zeros[87:83]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bus_command[1:0], report_valid[2], temperature_centi[17:3],
    // humidity_centi[31:18], sequence_state[34:32], disable_reason[37:35], zeros[39:38]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic     in_valid_reg;
    hss_in_t  in_reg;
    logic     out_valid_reg;
    hss_res_t out_reg;
    logic     advance;
    hss_cfg_t cfg;
    hss_res_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.now_ms          <= s_tdata[31:0];
            in_reg.device_present  <= s_tdata[32];
            in_reg.status_byte     <= s_tdata[40:33];
            in_reg.command_ack     <= s_tdata[41];
            in_reg.read_ok         <= s_tdata[42];
            in_reg.raw_humidity    <= s_tdata[62:43];
            in_reg.raw_temperature <= s_tdata[82:63];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    hss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hss_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.disable_reason, out_reg.sequence_state,
                       out_reg.humidity_centi, out_reg.temperature_centi,
                       out_reg.report_valid, out_reg.bus_command};

    // Disabled results always carry a report with both values zero.
    a_disabled_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.sequence_state == CODE_DISABLED
        |-> out_reg.report_valid && out_reg.temperature_centi == '0
            && out_reg.humidity_centi == '0)
        else $error("disabled result without a zero report");

endmodule
